### hw/rtl/mos_pkg.sv
// ----------------------------------------------------------------------------
// mos_pkg
// Shared constants and link type for the median-of-window sorting chain.
// ----------------------------------------------------------------------------
package mos_pkg;

	// window geometry
	localparam int WINDOW_SIZE = 11;
	localparam int SAMPLE_BITS = 10;
	localparam int CHAN_BITS   = 8;

	// fill counter width, at least one bit
	localparam int CNT_BITS = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

	// position of the median in the sorted chain
	localparam int MID_IDX = WINDOW_SIZE / 2;

	// last fill count of a window
	localparam logic [CNT_BITS-1:0] LAST_FILL = CNT_BITS'(WINDOW_SIZE - 1);

	// what one cell hands to its right neighbor
	typedef struct packed {
		logic                   gt;    // new sample goes at or before this cell
		logic                   valid; // cell holds a sample of this window
		logic [SAMPLE_BITS-1:0] value; // held sample
	} cell_link_t;

endpackage

### hw/rtl/mos_cell.sv
// ----------------------------------------------------------------------------
// mos_cell
// One slot of the sorted insertion chain: keeps its sample or takes the one
// from its left neighbor or the incoming sample.
// ----------------------------------------------------------------------------
module mos_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           ins,
	input  logic                           clr,
	input  logic [mos_pkg::SAMPLE_BITS-1:0] x,
	input  mos_pkg::cell_link_t            left,
	output mos_pkg::cell_link_t            right,
	output logic [mos_pkg::SAMPLE_BITS-1:0] value_next
);
	import mos_pkg::*;

	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] value_q;
	logic                   gt;

	// an empty slot counts as larger than any sample
	assign gt = !valid_q || (x < value_q);

	// shift right behind the insertion point, drop the sample in at it
	always_comb begin
		if (!gt) begin
			value_next = value_q;
		end else if (left.gt) begin
			value_next = left.value;
		end else begin
			value_next = x;
		end
	end

	assign right.gt    = gt;
	assign right.valid = valid_q;
	assign right.value = value_q;

	// occupancy grows as a thermometer from the left end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins) begin
			valid_q <= clr ? 1'b0 : left.valid;
		end
	end

	// sample payload
	always_ff @(posedge clk) begin
		if (ins) begin
			value_q <= value_next;
		end
	end

endmodule

### hw/rtl/median_of_sample_window.sv
// ----------------------------------------------------------------------------
// median_of_sample_window
// Median of non-overlapping windows of converter samples.
// ----------------------------------------------------------------------------
// Samples enter on start and busy is always low, so one sample is taken every
// cycle. Each sample is inserted into a chain of WINDOW_SIZE cells that keeps
// the window sorted; the insertion happens in the cycle the sample arrives.
// When the last sample of a window is taken, the median and the channel of
// that sample appear in the next cycle on median and result_channel with
// result_valid high for a single cycle; the receiver must take it then. The
// window is empty again right after, so the next sample may follow at once.
// ----------------------------------------------------------------------------
module median_of_sample_window (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [mos_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [mos_pkg::CHAN_BITS-1:0]   source_channel,
	output logic                            result_valid,
	output logic [mos_pkg::SAMPLE_BITS-1:0] median,
	output logic [mos_pkg::CHAN_BITS-1:0]   result_channel
);
	import mos_pkg::*;

	cell_link_t             links [WINDOW_SIZE+1];
	logic [SAMPLE_BITS-1:0] nexts [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0] valid_vec;
	logic                   accept;
	logic                   last;
	logic [CNT_BITS-1:0]    fill_q;
	logic                   result_valid_q;
	logic [SAMPLE_BITS-1:0] median_q;
	logic [CHAN_BITS-1:0]   channel_q;

	// one insertion per cycle, never stalled
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign last   = (fill_q == LAST_FILL);

	// head of the chain: nothing smaller, always occupied
	assign links[0].gt    = 1'b0;
	assign links[0].valid = 1'b1;
	assign links[0].value = '0;

	// sorted insertion chain
	for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
		mos_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ins        (accept),
			.clr        (last),
			.x          (sample),
			.left       (links[i]),
			.right      (links[i+1]),
			.value_next (nexts[i])
		);
		assign valid_vec[i] = links[i+1].valid;
	end

	// fill count of the current window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= last ? '0 : fill_q + 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= accept && last;
		end
	end

	// result payload taken from the middle cell as it updates
	always_ff @(posedge clk) begin
		if (accept && last) begin
			median_q  <= nexts[MID_IDX];
			channel_q <= source_channel;
		end
	end

	assign result_valid   = result_valid_q;
	assign median         = median_q;
	assign result_channel = channel_q;

	// fill count stays inside the window
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LAST_FILL)
		else $error("fill count beyond window");

	// occupied cells track the fill count
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(fill_q))
		else $error("cell occupancy differs from fill count");

	// a transaction that closes a window always gives a result
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> result_valid)
		else $error("closing transaction gave no result");

	// after a result the window is empty
	a_window_reset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(fill_q) == LAST_FILL) && (valid_vec == '0 || accept))
		else $error("window not restarted after result");

endmodule
